// File: src/dtwq_pkg.sv
// Shared types, codes and helpers for the delta-list timer wait queue.
package dtwq_pkg;

   localparam int DELTA_BITS      = 18;
   localparam int TASK_ID_BITS    = 8;
   localparam int TIMEOUT_BITS    = 16;
   localparam int STATUS_BITS     = 3;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ID_BITS     = 8;
   localparam int MAX_RESULTS     = 16;
   localparam int WAKE_BITS       = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_WAKEUP = 2'd3;

   localparam logic [STATUS_BITS-1:0] STAT_INSERTED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_REMOVED   = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_EXPIRED   = 3'd4;
   localparam logic [STATUS_BITS-1:0] STAT_NO_EXPIRY = 3'd5;
   localparam logic [STATUS_BITS-1:0] STAT_WOKEN     = 3'd6;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [TASK_ID_BITS-1:0] task_id;
      logic [TIMEOUT_BITS-1:0] timeout_ticks;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [TASK_ID_BITS-1:0] released_id;
      logic                    id_valid;
      logic                    last;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_SET_HEAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type                   op;
      logic                          pop_head;
      logic                          remove_search;
      logic signed [DELTA_BITS-1:0]  head_delta;
   } cell_cmd_type;

   typedef struct packed {
      logic signed [DELTA_BITS-1:0] delta;
      logic signed [DELTA_BITS-1:0] nd;
      logic                         chain;
      logic                         site;
   } link_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SETTLE,
      S_APPLY,
      S_WAKE
   } ctrl_state_type;

   function automatic logic signed [DELTA_BITS-1:0] sat_delta(input logic signed [31:0] v);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = (32'sd1 <<< (DELTA_BITS - 1)) - 32'sd1;
      lo = -(32'sd1 <<< (DELTA_BITS - 1));
      if (v > hi) begin
         return DELTA_BITS'(hi);
      end else if (v < lo) begin
         return DELTA_BITS'(lo);
      end
      return DELTA_BITS'(v);
   endfunction

endpackage

// File: src/delta_timer_wait_queue.sv
// Delta-list timer wait queue: sorted chain of timeout cells with sequencer.
//
// Usage: items arrive on req_valid/req_stall with req_data (opcode, task_id,
// timeout_ticks); results leave on rsp_valid/rsp_stall with rsp_data (status,
// released_id, id_valid, last). A transfer happens on a clock edge with valid
// high and stall low. csr_valid/csr_ready/csr_data writes wake_one_mode
// (csr_ready is always high); write it only while the queue is idle.
// One item is handled at a time. For insert and remove, running timeout
// sums and the first-match flag ripple through the cell chain one cell per
// cycle, then every cell shifts at once; tick skips the ripple. Wakeup gives
// one result per cycle while the output is not stalled, up to 16, the last
// one flagged; a new item is taken once the final result is in the output
// register, so a waiting result does not block the input.
// A stalled result holds in the output register and the sequencer waits.
// Reset (synchronous) empties the queue and clears wake_one_mode; no
// clearing pass follows, the block is ready in the next cycle.
module delta_timer_wait_queue #(
   parameter int QUEUE_DEPTH = dtwq_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = dtwq_pkg::DEF_ID_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dtwq_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dtwq_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data
);
   import dtwq_pkg::*;

   localparam int CUM_BITS = DELTA_BITS + $clog2(QUEUE_DEPTH) + 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic                        wake_one_ff, wake_one_in;
   cell_cmd_type                cmd;
   logic [ID_BITS-1:0]          key_id;
   logic [TIMEOUT_BITS-1:0]     key_t;
   logic [CNT_BITS-1:0]         count;
   logic [ID_BITS-1:0]          cell_id   [QUEUE_DEPTH];
   link_type                    cell_link [QUEUE_DEPTH];
   logic signed [CUM_BITS-1:0]  cell_cum  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]      site_vec;

   assign csr_ready   = 1'b1;
   assign wake_one_in = (csr_valid && csr_ready) ? csr_data : wake_one_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_one_ff <= 1'b0;
      end else begin
         wake_one_ff <= wake_one_in;
      end
   end

   dtwq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS),
      .CNT_BITS    (CNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .wake_one   (wake_one_ff),
      .head_id    (cell_id[0]),
      .head_delta (cell_link[0].delta),
      .found      (cell_link[QUEUE_DEPTH-1].chain),
      .cmd        (cmd),
      .key_id     (key_id),
      .key_t      (key_t),
      .count      (count)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_BITS-1:0]         l_id, r_id;
      link_type                   l_link, r_link;
      logic signed [CUM_BITS-1:0] l_cum;
      logic                       occ;

      if (i == 0) begin : g_first
         assign l_id   = '0;
         assign l_link = '0;
         assign l_cum  = '0;
      end else begin : g_left
         assign l_id   = cell_id[i-1];
         assign l_link = cell_link[i-1];
         assign l_cum  = cell_cum[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_id   = cell_id[i];
         assign r_link = cell_link[i];
      end else begin : g_right
         assign r_id   = cell_id[i+1];
         assign r_link = cell_link[i+1];
      end

      assign occ         = (CNT_BITS'(i) < count);
      assign site_vec[i] = cell_link[i].site;

      dtwq_cell #(
         .ID_BITS  (ID_BITS),
         .CUM_BITS (CUM_BITS),
         .IS_HEAD  (i == 0)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key_id     (key_id),
         .key_t      (key_t),
         .occupied   (occ),
         .left_id    (l_id),
         .left_link  (l_link),
         .left_cum   (l_cum),
         .right_id   (r_id),
         .right_link (r_link),
         .id_out     (cell_id[i]),
         .link_out   (cell_link[i]),
         .cum_out    (cell_cum[i])
      );
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_BITS'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count == $past(count) || count == $past(count) + 1'b1
                || count == $past(count) - 1'b1))
      else $error("entry count moved by more than one");

   a_insert_site: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CELL_INSERT) |-> $onehot(site_vec))
      else $error("insert without a single insertion cell");

   a_remove_site: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CELL_REMOVE && !cmd.pop_head) |-> $onehot(site_vec))
      else $error("remove without a single matching cell");
`endif

endmodule

// File: src/dtwq_cell.sv
// One queue cell: an entry, its running timeout sum and its neighbour links.
module dtwq_cell #(
   parameter int ID_BITS  = dtwq_pkg::DEF_ID_BITS,
   parameter int CUM_BITS = dtwq_pkg::DELTA_BITS + 5,
   parameter bit IS_HEAD  = 1'b0
) (
   input  logic                                clock,
   input  dtwq_pkg::cell_cmd_type              cmd,
   input  logic [ID_BITS-1:0]                  key_id,
   input  logic [dtwq_pkg::TIMEOUT_BITS-1:0]   key_t,
   input  logic                                occupied,
   input  logic [ID_BITS-1:0]                  left_id,
   input  dtwq_pkg::link_type                  left_link,
   input  logic signed [CUM_BITS-1:0]          left_cum,
   input  logic [ID_BITS-1:0]                  right_id,
   input  dtwq_pkg::link_type                  right_link,
   output logic [ID_BITS-1:0]                  id_out,
   output dtwq_pkg::link_type                  link_out,
   output logic signed [CUM_BITS-1:0]          cum_out
);
   import dtwq_pkg::*;

   logic [ID_BITS-1:0]           id_ff, id_in;
   logic signed [DELTA_BITS-1:0] delta_ff, delta_in;
   logic signed [DELTA_BITS-1:0] nd_ff, own_delta;
   logic signed [CUM_BITS-1:0]   cum_ff, key_ext;
   logic                         before_ff, hit, site, eff_site, eff_before;

   assign key_ext = CUM_BITS'($signed({1'b0, key_t}));
   assign hit     = cmd.remove_search ? (occupied && id_ff == key_id)
                                      : (!occupied || cum_ff > key_ext);
   assign site    = hit && !before_ff;

   // running sums and first-hit flag ripple one cell per cycle
   always_ff @(posedge clock) begin
      cum_ff    <= left_cum + CUM_BITS'(delta_ff);
      before_ff <= left_link.chain;
      nd_ff     <= sat_delta(32'(key_ext) - 32'(left_cum));
      id_ff     <= id_in;
      delta_ff  <= delta_in;
   end

   always_comb begin
      id_in      = id_ff;
      delta_in   = delta_ff;
      eff_site   = cmd.pop_head ? IS_HEAD : site;
      eff_before = cmd.pop_head ? !IS_HEAD : before_ff;
      own_delta  = (cmd.pop_head && IS_HEAD) ? cmd.head_delta : delta_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (site) begin
               id_in    = key_id;
               delta_in = nd_ff;
            end else if (before_ff) begin
               id_in    = left_id;
               delta_in = left_link.site
                        ? sat_delta(32'(left_link.delta) - 32'(left_link.nd))
                        : left_link.delta;
            end
         end
         CELL_REMOVE: begin
            if (eff_site) begin
               id_in    = right_id;
               delta_in = sat_delta(32'(right_link.delta) + 32'(own_delta));
            end else if (eff_before) begin
               id_in    = right_id;
               delta_in = right_link.delta;
            end
         end
         CELL_SET_HEAD: begin
            if (IS_HEAD) begin
               delta_in = cmd.head_delta;
            end
         end
         CELL_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   assign id_out   = id_ff;
   assign link_out = '{delta: delta_ff, nd: nd_ff, chain: before_ff | hit, site: site};
   assign cum_out  = cum_ff;

endmodule

// File: src/dtwq_ctrl.sv
// Sequencer: input transfer, entry count, cell commands and the result register.
module dtwq_ctrl #(
   parameter int QUEUE_DEPTH = dtwq_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = dtwq_pkg::DEF_ID_BITS,
   parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dtwq_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dtwq_pkg::rsp_type                   rsp_data,
   input  logic                                wake_one,
   input  logic [ID_BITS-1:0]                  head_id,
   input  logic signed [dtwq_pkg::DELTA_BITS-1:0] head_delta,
   input  logic                                found,
   output dtwq_pkg::cell_cmd_type              cmd,
   output logic [ID_BITS-1:0]                  key_id,
   output logic [dtwq_pkg::TIMEOUT_BITS-1:0]   key_t,
   output logic [CNT_BITS-1:0]                 count
);
   import dtwq_pkg::*;

   localparam int WAIT_BITS = $clog2(QUEUE_DEPTH);

   ctrl_state_type               state_ff, state_in;
   logic [1:0]                   op_ff, op_in;
   logic [ID_BITS-1:0]           key_id_ff, key_id_in;
   logic [TIMEOUT_BITS-1:0]      key_t_ff, key_t_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic [WAIT_BITS-1:0]         wait_ff, wait_in;
   logic [WAKE_BITS-1:0]         nwake_ff, nwake_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;
   logic                         accept, out_free, full, wake_last;
   logic signed [DELTA_BITS-1:0] head_dec;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_dec  = sat_delta(32'(head_delta) - 32'sd1);
   assign wake_last = (count_ff == CNT_BITS'(1)) || wake_one
                   || (nwake_ff == WAKE_BITS'(MAX_RESULTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         nwake_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         nwake_ff     <= nwake_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_id_ff <= key_id_in;
      key_t_ff  <= key_t_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      wait_in      = wait_ff;
      nwake_in     = nwake_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      op_in        = op_ff;
      key_id_in    = key_id_ff;
      key_t_in     = key_t_ff;
      cmd          = '{op: CELL_HOLD, pop_head: 1'b0,
                       remove_search: (op_ff == OP_REMOVE), head_delta: head_delta};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_data.opcode;
               key_id_in = ID_BITS'(req_data.task_id);
               key_t_in  = req_data.timeout_ticks;
               wait_in   = '0;
               nwake_in  = '0;
               case (req_data.opcode)
                  OP_INSERT: state_in = S_SETTLE;
                  OP_REMOVE: state_in = S_SETTLE;
                  OP_TICK:   state_in = S_APPLY;
                  default:   state_in = S_WAKE;
               endcase
            end
         end
         S_SETTLE: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WAIT_BITS'(QUEUE_DEPTH - 1)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               case (op_ff)
                  OP_INSERT: begin
                     if (full) begin
                        rsp_in = '{status: STAT_FULL, released_id: '0,
                                   id_valid: 1'b0, last: 1'b1};
                     end else begin
                        cmd.op   = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                        rsp_in   = '{status: STAT_INSERTED,
                                     released_id: TASK_ID_BITS'(key_id_ff),
                                     id_valid: 1'b1, last: 1'b1};
                     end
                  end
                  OP_REMOVE: begin
                     if (found) begin
                        cmd.op   = CELL_REMOVE;
                        count_in = count_ff - 1'b1;
                        rsp_in   = '{status: STAT_REMOVED,
                                     released_id: TASK_ID_BITS'(key_id_ff),
                                     id_valid: 1'b1, last: 1'b1};
                     end else begin
                        rsp_in = '{status: STAT_NOT_FOUND, released_id: '0,
                                   id_valid: 1'b0, last: 1'b1};
                     end
                  end
                  OP_TICK: begin
                     rsp_in = '{status: STAT_NO_EXPIRY, released_id: '0,
                                id_valid: 1'b0, last: 1'b1};
                     if (count_ff != '0) begin
                        cmd.head_delta = head_dec;
                        if (head_dec[DELTA_BITS-1] || head_dec == '0) begin
                           cmd.op       = CELL_REMOVE;
                           cmd.pop_head = 1'b1;
                           count_in     = count_ff - 1'b1;
                           rsp_in       = '{status: STAT_EXPIRED,
                                            released_id: TASK_ID_BITS'(head_id),
                                            id_valid: 1'b1, last: 1'b1};
                        end else begin
                           cmd.op = CELL_SET_HEAD;
                        end
                     end
                  end
                  default: begin
                     rsp_in = '{status: STAT_WOKEN, released_id: '0,
                                id_valid: 1'b0, last: 1'b1};
                  end
               endcase
            end
         end
         S_WAKE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_in   = '{status: STAT_WOKEN, released_id: '0,
                               id_valid: 1'b0, last: 1'b1};
                  state_in = S_IDLE;
               end else begin
                  cmd.op       = CELL_REMOVE;
                  cmd.pop_head = 1'b1;
                  count_in     = count_ff - 1'b1;
                  nwake_in     = nwake_ff + 1'b1;
                  rsp_in       = '{status: STAT_WOKEN,
                                   released_id: TASK_ID_BITS'(head_id),
                                   id_valid: 1'b1, last: wake_last};
                  if (wake_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign key_id    = key_id_ff;
   assign key_t     = key_t_ff;
   assign count     = count_ff;

endmodule
